>>> rtl/core/byte_ring_fifo_with_line_fetch_core_defines.svh
// Assertion helpers shared by the byte ring FIFO core.
`ifndef BYTE_RING_FIFO_WITH_LINE_FETCH_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_LINE_FETCH_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BRF_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> rtl/core/brf_pkg.sv
package brf_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int CAP_LIMIT     = 64;
   localparam int BYTE_W        = 8;
   localparam int CAP_W         = 7;
   localparam int LEN_W         = 6;

   localparam logic [BYTE_W-1:0] CR_BYTE = 8'd13;

   localparam logic [1:0] MODE_PUT  = 2'd0;
   localparam logic [1:0] MODE_GET  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;
   localparam logic [1:0] MODE_LINE = 2'd3;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;
   localparam logic [1:0] STAT_NO_LINE = 2'd3;

   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [1:0]        mode;
      logic [BYTE_W-1:0] byte_in;
      logic [CAP_W-1:0]  max_line;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_out;
      logic [1:0]        status;
      logic              last;
      logic [CAP_W-1:0]  fill_level;
   } rsp_type;

endpackage

>>> rtl/core/byte_ring_fifo_with_line_fetch_core.sv
// Channel   Direction  Ports                       Transaction
// req       in         req_valid/req_stall/req_data  one put, get, peek or get-line request
// rsp       out        rsp_valid/rsp_stall/rsp_data  one result byte or status
// csr       in/out     csr_psel ... csr_pready      capacity register write or read
//
// Put, an empty get or peek, and any failing request on an empty FIFO give their
// result in the cycle after acceptance; get and peek with data go through the
// READ state first (one memory read). Get-line scans one byte a cycle through
// the memory read port (up to the fill level), then emits one byte a cycle
// while rsp is not stalled. Only one request is in flight; the next one is taken
// at the edge where the pending result leaves the output register. Reset is
// synchronous, needs no clearing pass, and restores capacity to its maximum.
module byte_ring_fifo_with_line_fetch_core #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import brf_pkg::*;

   // only entries below the capacity limit are reachable
   localparam int USE_DEPTH = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
   localparam int PW        = $clog2(USE_DEPTH);
   localparam logic [CAP_W-1:0] CAP_TOP = CAP_W'(USE_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [PW-1:0]    wr_pos_ff, wr_pos_in;
   logic [PW-1:0]    rd_pos_ff, rd_pos_in;
   logic [CAP_W-1:0] count_ff, count_in;
   logic [PW-1:0]    scan_pos_ff, scan_pos_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [CAP_W-1:0] max_line_ff, max_line_in;
   logic [1:0]       mode_ff, mode_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              ram_we;
   logic [PW-1:0]     ram_waddr;
   logic [BYTE_W-1:0] ram_wdata;
   logic              ram_re;
   logic [PW-1:0]     ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   logic             rsp_free;
   logic             req_accept;
   logic             cfg_write;
   logic [CAP_W-1:0] cfg_cap;
   logic [PW-1:0]    rd_next;

   // wrap at the configured capacity
   function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] n;
      n = CAP_W'(p) + CAP_W'(1);
      if (n >= cap) begin
         adv = '0;
      end else begin
         adv = n[PW-1:0];
      end
   endfunction

   function automatic rsp_type mk_rsp(input logic [BYTE_W-1:0] b, input logic [1:0] st,
                                      input logic lst, input logic [CAP_W-1:0] fill);
      rsp_type r;
      r.byte_out   = b;
      r.status     = st;
      r.last       = lst;
      r.fill_level = fill;
      mk_rsp = r;
   endfunction

   brf_ram #(
      .ENTRIES (USE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register frees when its transaction is taken
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // APB side: zero-wait, one register
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? 32'(cap_ff) : 32'd0;

   // clamp the written capacity to 1..limit
   always_comb begin
      cfg_cap = csr_pwdata[CAP_W-1:0];
      if (cfg_cap == '0) begin
         cfg_cap = CAP_W'(1);
      end else if (cfg_cap > CAP_TOP) begin
         cfg_cap = CAP_TOP;
      end
   end

   assign rd_next = adv(rd_pos_ff, cap_ff);

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      count_in     = count_ff;
      scan_pos_in  = scan_pos_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      max_line_in  = max_line_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_pos_ff;
      ram_wdata    = req_data.byte_in;
      ram_re       = 1'b0;
      ram_raddr    = rd_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.mode)
                  MODE_PUT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff >= cap_ff) begin
                        rsp_in = mk_rsp('0, STAT_FULL, 1'b1, count_ff);
                     end else begin
                        ram_we    = 1'b1;
                        wr_pos_in = adv(wr_pos_ff, cap_ff);
                        count_in  = count_ff + CAP_W'(1);
                        rsp_in    = mk_rsp('0, STAT_OK, 1'b1, count_ff + CAP_W'(1));
                     end
                  end
                  MODE_GET, MODE_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = mk_rsp('0, STAT_EMPTY, 1'b1, count_ff);
                     end else begin
                        ram_re   = 1'b1;
                        mode_in  = req_data.mode;
                        state_in = ST_READ;
                     end
                  end
                  MODE_LINE: begin
                     max_line_in = req_data.max_line;
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = mk_rsp('0, STAT_NO_LINE, 1'b1, count_ff);
                     end else begin
                        // first read at the head, next address queued behind it
                        ram_re      = 1'b1;
                        scan_pos_in = rd_next;
                        idx_in      = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (mode_ff == MODE_GET) begin
               rd_pos_in = rd_next;
               count_in  = count_ff - CAP_W'(1);
               rsp_in    = mk_rsp(ram_rdata, STAT_OK, 1'b1, count_ff - CAP_W'(1));
            end else begin
               rsp_in = mk_rsp(ram_rdata, STAT_OK, 1'b1, count_ff);
            end
         end
         ST_SCAN: begin
            if (ram_rdata == CR_BYTE) begin
               if ((idx_ff == '0) || (CAP_W'(idx_ff) >= max_line_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = mk_rsp('0, STAT_NO_LINE, 1'b1, count_ff);
                  state_in     = ST_IDLE;
               end else begin
                  // rewind to the head and emit the line
                  left_in  = idx_ff;
                  ram_re   = 1'b1;
                  state_in = ST_EMIT;
               end
            end else if (CAP_W'(idx_ff) + CAP_W'(1) == count_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = mk_rsp('0, STAT_NO_LINE, 1'b1, count_ff);
               state_in     = ST_IDLE;
            end else begin
               ram_re      = 1'b1;
               ram_raddr   = scan_pos_ff;
               scan_pos_in = adv(scan_pos_ff, cap_ff);
               idx_in      = idx_ff + LEN_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (left_ff == LEN_W'(1)) begin
                  // drop the carriage return with the final byte
                  rd_pos_in = adv(rd_next, cap_ff);
                  count_in  = count_ff - CAP_W'(2);
                  rsp_in    = mk_rsp(ram_rdata, STAT_OK, 1'b1, count_ff - CAP_W'(2));
                  state_in  = ST_IDLE;
               end else begin
                  rd_pos_in = rd_next;
                  count_in  = count_ff - CAP_W'(1);
                  left_in   = left_ff - LEN_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = rd_next;
                  rsp_in    = mk_rsp(ram_rdata, STAT_OK, 1'b0, count_ff - CAP_W'(1));
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // capacity write empties the FIFO
      if (cfg_write) begin
         cap_in    = cfg_cap;
         wr_pos_in = '0;
         rd_pos_in = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_TOP;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping
   always_ff @(posedge clock) begin
      scan_pos_ff <= scan_pos_in;
      idx_ff      <= idx_in;
      left_ff     <= left_in;
      max_line_ff <= max_line_in;
      mode_ff     <= mode_in;
      rsp_ff      <= rsp_in;
   end

`include "byte_ring_fifo_with_line_fetch_core_defines.svh"

   `BRF_ASSERT(a_count_in_cap, count_ff <= cap_ff, "fill count beyond capacity")
   `BRF_ASSERT(a_pos_in_cap, (CAP_W'(rd_pos_ff) < cap_ff) && (CAP_W'(wr_pos_ff) < cap_ff), "ring position beyond capacity")
   `BRF_ASSERT(a_accept_follows, req_accept |=> (rsp_valid_ff || (state_ff != ST_IDLE)), "accepted request left no work")
   `BRF_ASSERT(a_emit_left, (state_ff == ST_EMIT) |-> ((left_ff != '0) && (CAP_W'(left_ff) < count_ff)), "line emit beyond held bytes")
   `BRF_NEVER(a_no_emit_overwrite, (state_ff == ST_READ) && rsp_valid_ff, "output register busy at read result")

endmodule

>>> rtl/core/brf_ram.sv
module brf_ram #(
   parameter int ENTRIES = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [brf_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [brf_pkg::BYTE_W-1:0] rd_data
);
   import brf_pkg::*;

   logic [BYTE_W-1:0] mem [ENTRIES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> bench/byte_ring_fifo_with_line_fetch_checker.sv
`timescale 1ns / 100ps

module byte_ring_fifo_with_line_fetch_checker #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  brf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  brf_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               fail_count,
   output int               results_pending
);
   import brf_pkg::*;

   logic [BYTE_W-1:0] ring_bytes [DEPTH];
   int                head_pos;
   int                tail_pos;
   logic [CAP_W-1:0]  held_count;
   logic [CAP_W-1:0]  active_cap;
   rsp_type           expected_results [$];
   int                mismatches = 0;
   int                waiting = 0;

   assign fail_count      = mismatches;
   assign results_pending = waiting;

   function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] raw);
      int top_cap;
      top_cap = (DEPTH < CAP_LIMIT) ? DEPTH : CAP_LIMIT;
      if (raw < 1) return CAP_W'(1);
      if (int'(raw) > top_cap) return CAP_W'(top_cap);
      return raw;
   endfunction

   function automatic int next_pos(input int pos);
      int n;
      n = pos + 1;
      if (n >= int'(active_cap) || n >= DEPTH) n = 0;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] pop_oldest();
      logic [BYTE_W-1:0] b;
      b          = ring_bytes[head_pos];
      head_pos   = next_pos(head_pos);
      held_count = held_count - CAP_W'(1);
      return b;
   endfunction

   task automatic push_result(input logic [BYTE_W-1:0] b, input logic [1:0] st,
                              input logic fin);
      rsp_type r;
      r.byte_out   = b;
      r.status     = st;
      r.last       = fin;
      r.fill_level = held_count;
      expected_results.push_back(r);
   endtask

   task automatic predict_fifo_results(input req_type item);
      int                scan_pos;
      int                line_len;
      int                j;
      bit                found;
      logic [BYTE_W-1:0] b;
      case (item.mode)
         MODE_PUT: begin
            if (held_count >= active_cap) begin
               push_result('0, STAT_FULL, 1'b1);
            end else begin
               ring_bytes[tail_pos] = item.byte_in;
               tail_pos   = next_pos(tail_pos);
               held_count = held_count + CAP_W'(1);
               push_result('0, STAT_OK, 1'b1);
            end
         end
         MODE_GET, MODE_PEEK: begin
            if (held_count == 0) begin
               push_result('0, STAT_EMPTY, 1'b1);
            end else begin
               if (item.mode == MODE_GET) b = pop_oldest();
               else b = ring_bytes[head_pos];
               push_result(b, STAT_OK, 1'b1);
            end
         end
         default: begin
            // find the first carriage return among the held bytes
            line_len = 0;
            found    = 1'b0;
            scan_pos = head_pos;
            for (j = 0; j < int'(held_count); j++) begin
               if (!found && ring_bytes[scan_pos] == CR_BYTE) begin
                  line_len = j;
                  found    = 1'b1;
               end
               scan_pos = next_pos(scan_pos);
            end
            if (line_len < 1 || line_len >= int'(item.max_line)) begin
               push_result('0, STAT_NO_LINE, 1'b1);
            end else begin
               for (j = 0; j < line_len; j++) begin
                  b = pop_oldest();
                  // drop the carriage return along with the final byte
                  if (j == line_len - 1) void'(pop_oldest());
                  push_result(b, STAT_OK, j == line_len - 1);
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         head_pos   = 0;
         tail_pos   = 0;
         held_count = '0;
         active_cap = clamp_capacity(CAP_W'(CAP_LIMIT));
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result byte_out=%0d status=%0d last=%0d fill_level=%0d",
                        $time, rsp_data.byte_out, rsp_data.status, rsp_data.last,
                        rsp_data.fill_level);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  $display("%0t: result mismatch, expected byte_out=%0d status=%0d last=%0d fill_level=%0d, actual byte_out=%0d status=%0d last=%0d fill_level=%0d",
                           $time, want.byte_out, want.status, want.last, want.fill_level,
                           rsp_data.byte_out, rsp_data.status, rsp_data.last,
                           rsp_data.fill_level);
               end
            end
         end
         if (req_valid && !req_stall) predict_fifo_results(req_data);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            // a capacity write also empties the ring
            if (csr_paddr[2] == REG_CAPACITY) begin
               active_cap = clamp_capacity(csr_pwdata[CAP_W-1:0]);
               head_pos   = 0;
               tail_pos   = 0;
               held_count = '0;
            end
         end
      end
      waiting = expected_results.size();
   end

endmodule

>>> bench/byte_ring_fifo_with_line_fetch_core_test.sv
`timescale 1ns / 100ps

module byte_ring_fifo_with_line_fetch_core_test;
   import brf_pkg::*;

   // Generous bound: far above the slowest legal run of this stimulus.
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int results_pending;
   int cycle_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   byte_ring_fifo_with_line_fetch_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The checker watches both channels and the config port on its own.
   byte_ring_fifo_with_line_fetch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   // Stall the result channel at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one transaction and hold it until accepted. Stall is sampled at the
   // falling edge, where it is settled, and the transaction counts at the next
   // rising edge. Called and left just after a rising edge.
   task automatic send_request(input logic [1:0] mode, input logic [7:0] data,
                               input logic [6:0] limit);
      req_type item;
      bit      taken;
      item.mode     = mode;
      item.byte_in  = data;
      item.max_line = limit;
      // idle gap before the transaction; valid is lowered here and in wait_for_drain
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Drop valid and hold off until every expected result has come back, then
   // let the block settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the write lands when pready is seen.
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      bit ready;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      ready = 1'b0;
      while (!ready) begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write capacity only once the block is idle.
   task automatic set_capacity(input logic [31:0] value);
      wait_for_drain();
      csr_write(3'd0, value);
   endtask

   // Either a well-formed line (up to eight non-CR bytes, a CR, then a fetch) or a
   // single random transaction as noise.
   task automatic random_action();
      int         line_bytes;
      int         i;
      logic [7:0] b;
      logic [6:0] limit;
      if ($urandom_range(99) < 55) begin
         line_bytes = $urandom_range(8);
         for (i = 0; i < line_bytes; i++) begin
            b = 8'($urandom_range(255));
            if (b == CR_BYTE) b = 8'h0c;
            send_request(MODE_PUT, b, 7'($urandom_range(127)));
         end
         send_request(MODE_PUT, CR_BYTE, 7'($urandom_range(127)));
         // mostly a limit that lets the line through, sometimes anything
         if ($urandom_range(99) < 75) limit = 7'(line_bytes + 1 + $urandom_range(3));
         else limit = 7'($urandom_range(127));
         send_request(MODE_LINE, 8'($urandom_range(255)), limit);
      end else begin
         b = ($urandom_range(99) < 30) ? CR_BYTE : 8'($urandom_range(255));
         send_request(2'($urandom_range(3)), b, 7'($urandom_range(127)));
      end
   endtask

   initial begin
      int phase;
      int phase_start;
      bit paused;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset capacity, no idling.
      send_request(MODE_GET,  8'h00, 7'd1);    // get on empty
      send_request(MODE_PEEK, 8'hff, 7'd64);   // peek on empty
      send_request(MODE_LINE, 8'h00, 7'd64);   // line on empty
      send_request(MODE_PUT,  8'h00, 7'd0);
      send_request(MODE_PUT,  8'hff, 7'd127);
      send_request(MODE_PEEK, 8'h00, 7'd0);
      send_request(MODE_GET,  8'h00, 7'd0);
      send_request(MODE_PUT,  CR_BYTE, 7'd0);
      send_request(MODE_LINE, 8'h00, 7'd2);    // one-byte line at the tightest limit
      send_request(MODE_PUT,  CR_BYTE, 7'd0);
      send_request(MODE_LINE, 8'h00, 7'd64);   // carriage return at the head
      send_request(MODE_GET,  8'h00, 7'd0);
      send_request(MODE_PUT,  8'h41, 7'd0);
      send_request(MODE_PUT,  8'h42, 7'd0);
      send_request(MODE_PUT,  CR_BYTE, 7'd0);
      send_request(MODE_LINE, 8'h00, 7'd2);    // line not shorter than the limit
      send_request(MODE_LINE, 8'h00, 7'd0);    // zero limit
      send_request(MODE_LINE, 8'h00, 7'd127);
      send_request(MODE_PUT,  8'h55, 7'd0);
      send_request(MODE_LINE, 8'h00, 7'd64);   // no carriage return held
      // write past the register list: ignored, the byte must survive
      wait_for_drain();
      csr_write(3'd4, 32'h0000_0001);
      send_request(MODE_GET,  8'h00, 7'd0);
      // zero capacity acts as one entry
      set_capacity(32'h0000_0000);
      send_request(MODE_PUT,  8'haa, 7'd0);
      send_request(MODE_PUT,  8'h5a, 7'd0);    // full, rejected
      send_request(MODE_PEEK, 8'h00, 7'd0);
      send_request(MODE_LINE, 8'h00, 7'd64);

      // Random part: one idling profile and one capacity per phase.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               set_capacity(32'd64);
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               set_capacity(32'd16);
               send_idle_pct = 86;
               stall_pct     = 0;
            end
            2: begin
               set_capacity(32'd5);
               send_idle_pct = 0;
               stall_pct     = 86;
            end
            default: begin
               // junk in the upper bits, 127 in the field: clamps to the top
               set_capacity({25'($urandom_range(32'h01ff_ffff, 0)), 7'd127});
               send_idle_pct = 37;
               stall_pct     = 37;
            end
         endcase
         phase_start = items_sent;
         paused      = 1'b0;
         while (items_sent < phase_start + 16) begin
            random_action();
            // hold off mid-phase until every result is back
            if (!paused && items_sent >= phase_start + 8) begin
               wait_for_drain();
               paused = 1'b1;
            end
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
